// ----- hdl/efsf_pkg.sv -----
// Shared constants, types and sequencer states of the EMA sensor framer.
package efsf_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int SAMPLE_BITS  = 10;

    localparam int SAMPLE_W = 10;
    localparam int LEVEL_W  = 10;
    localparam int FACTOR_W = 16;
    localparam int COUNT_W  = 3;
    localparam int JOY_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam int DIGIT_SHIFT = 5;
    localparam int PROD_W      = LEVEL_W + 1 + FACTOR_W + 1;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [BYTE_W-1:0]   TERMINATOR   = 8'd90;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd32768;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 3'd2;

    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef struct packed {
        logic [FACTOR_W-1:0] filter_factor;
        logic [COUNT_W-1:0]  channel_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_HI,
        ST_LO,
        ST_BTN,
        ST_TERM
    } state_t;

endpackage

// ----- hdl/efsf_ifs.sv -----
// Stream interfaces for acquisitions in and frame bytes out.
interface efsf_acq_if
    import efsf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_zero;
    logic [SAMPLE_W-1:0] sample_one;
    logic [SAMPLE_W-1:0] sample_two;
    logic [SAMPLE_W-1:0] sample_three;
    logic [JOY_W-1:0]    joystick_levels;

    modport source (
        output valid, sample_zero, sample_one, sample_two, sample_three, joystick_levels,
        input  ready
    );
    modport sink (
        input  valid, sample_zero, sample_one, sample_two, sample_three, joystick_levels,
        output ready
    );
endinterface

interface efsf_frame_if
    import efsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;

    modport source (
        output valid, frame_byte, frame_last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_last,
        output ready
    );
endinterface

// ----- hdl/efsf_cfg_regs.sv -----
// APB configuration registers: filter factor and active channel count.
module efsf_cfg_regs
    import efsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [FACTOR_W-1:0] factor_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= FACTOR_RESET;
            count_reg  <= COUNT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_FACTOR: factor_reg <= pwdata[FACTOR_W-1:0];
                REG_COUNT:  count_reg  <= pwdata[COUNT_W-1:0];
                default:    factor_reg <= factor_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_FACTOR: prdata = DATA_W'(factor_reg);
            REG_COUNT:  prdata = DATA_W'(count_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.filter_factor = factor_reg;
    assign cfg.channel_count = count_reg;

endmodule

// ----- hdl/efsf_level_ram.sv -----
// Filtered level store: one write port, one registered read port.
module efsf_level_ram
    import efsf_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [CH_W-1:0]    waddr,
    input  logic [LEVEL_W-1:0] wdata,
    input  logic               re,
    input  logic [CH_W-1:0]    raddr,
    output logic [LEVEL_W-1:0] rdata
);

    logic [LEVEL_W-1:0] mem [MAX_CHANNELS];
    logic [LEVEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/efsf_ema_unit.sv -----
// EMA update: sample + (old - sample) * f / 65536, one multiply then one add.
module efsf_ema_unit
    import efsf_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [LEVEL_W-1:0]  old_level,
    input  logic [LEVEL_W-1:0]  sample,
    input  logic [FACTOR_W-1:0] factor,
    output logic [LEVEL_W-1:0]  level
);

    logic signed [LEVEL_W:0]   diff;
    logic signed [FACTOR_W:0]  factor_s;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [LEVEL_W-1:0]        sample_reg;
    logic signed [PROD_W-1:0]  acc;

    assign diff     = $signed({1'b0, old_level}) - $signed({1'b0, sample});
    assign factor_s = $signed({1'b0, factor});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Widen both operands so the signed product keeps all its bits.
            prod_reg   <= PROD_W'(diff) * PROD_W'(factor_s);
            sample_reg <= sample;
        end
    end

    // Sum is never negative and stays below 2^(LEVEL_W+16).
    assign acc   = $signed({PROD_W'(sample_reg) << FACTOR_W}) + prod_reg;
    assign level = acc[FACTOR_W +: LEVEL_W];

endmodule

// ----- hdl/ema_filter_sensor_framer_top.sv -----
// EMA sensor framer top level: sequencer around the level store and frame output.
//
// One acquisition enters on acq (valid/ready) when the block is idle. Each
// active channel (channel_count, saturated at four) reads its filtered level
// from the store, runs it through the EMA unit and writes it back, then the
// frame channel carries the level divided by 32 and the level modulo 32.
// After the channels come the inverted joystick nibble and the terminator 90
// with frame_last set.
// Sequence: per active channel the sequencer steps through read, multiply,
// add/write-back and the two byte slots; a further acquisition is taken only
// once the terminator has been emitted and the sequencer is back in idle.
// The frame output is a register: a stalled receiver holds the current byte
// and the sequencer waits in its byte state; nothing is dropped.
// Reset clears the filter levels to zero through per-entry valid bits and
// loads the factor 32768 and a channel count of two. Configuration is
// written over APB at byte addresses 0 and 4.
module ema_filter_sensor_framer_top
    import efsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    efsf_acq_if.sink          acq,
    efsf_frame_if.source      frame
);

    cfg_t cfg;

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]     chan_reg;
    logic [COUNT_W-1:0]     nch_reg;
    logic [COUNT_W-1:0]     nch_sat;
    logic [COUNT_W-1:0]     chan_inc;
    logic [CH_W-1:0]        chan_idx;
    logic [LEVEL_W-1:0]     sample_reg [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]    raw [4];
    logic [JOY_W-1:0]       joy_reg;
    logic [LEVEL_W-1:0]     level_reg;
    logic [MAX_CHANNELS-1:0] valid_reg;

    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_byte_reg;
    logic                   out_last_reg;
    logic                   out_free;

    logic                   accept;
    logic                   ram_re;
    logic                   ram_we;
    logic                   mul_en;
    logic                   emit;
    logic [BYTE_W-1:0]      emit_byte;
    logic                   emit_last;
    logic [LEVEL_W-1:0]     ram_rdata;
    logic [LEVEL_W-1:0]     old_level;
    logic [LEVEL_W-1:0]     new_level;

    efsf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    efsf_level_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (chan_idx),
        .wdata (new_level),
        .re    (ram_re),
        .raddr (chan_idx),
        .rdata (ram_rdata)
    );

    // Entries never written since reset read as zero.
    assign old_level = valid_reg[chan_idx] ? ram_rdata : '0;

    efsf_ema_unit u_ema (
        .clk       (clk),
        .en        (mul_en),
        .old_level (old_level),
        .sample    (sample_reg[chan_idx]),
        .factor    (cfg.filter_factor),
        .level     (new_level)
    );

    assign chan_idx = chan_reg[CH_W-1:0];
    assign chan_inc = chan_reg + COUNT_W'(1);
    assign nch_sat  = (cfg.channel_count > COUNT_W'(MAX_CHANNELS)) ?
                      COUNT_W'(MAX_CHANNELS) : cfg.channel_count;
    assign out_free = !out_valid_reg || frame.ready;
    assign accept   = acq.valid && acq.ready;

    assign raw[0] = acq.sample_zero;
    assign raw[1] = acq.sample_one;
    assign raw[2] = acq.sample_two;
    assign raw[3] = acq.sample_three;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acq.valid)
                begin
                    state_next = (nch_sat == '0) ? ST_BTN : ST_READ;
                end
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_HI;
            ST_HI:
            begin
                if (out_free)
                begin
                    state_next = ST_LO;
                end
            end
            ST_LO:
            begin
                if (out_free)
                begin
                    state_next = (chan_inc == nch_reg) ? ST_BTN : ST_READ;
                end
            end
            ST_BTN:
            begin
                if (out_free)
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        acq.ready = 1'b0;
        ram_re    = 1'b0;
        mul_en    = 1'b0;
        ram_we    = 1'b0;
        emit      = 1'b0;
        emit_byte = '0;
        emit_last = 1'b0;
        case (state_reg)
            ST_IDLE: acq.ready = 1'b1;
            ST_READ: ram_re = 1'b1;
            ST_MUL:  mul_en = 1'b1;
            ST_SUM:  ram_we = 1'b1;
            ST_HI:
            begin
                emit      = out_free;
                emit_byte = BYTE_W'(level_reg >> DIGIT_SHIFT);
            end
            ST_LO:
            begin
                emit      = out_free;
                emit_byte = BYTE_W'(level_reg[DIGIT_SHIFT-1:0]);
            end
            ST_BTN:
            begin
                emit      = out_free;
                emit_byte = BYTE_W'({~joy_reg[0], ~joy_reg[1], ~joy_reg[2], ~joy_reg[3]});
            end
            ST_TERM:
            begin
                emit      = out_free;
                emit_byte = TERMINATOR;
                emit_last = 1'b1;
            end
            default: acq.ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chan_reg      <= '0;
            nch_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                chan_reg <= '0;
                nch_reg  <= nch_sat;
            end
            else if (state_reg == ST_LO && out_free)
            begin
                chan_reg <= chan_inc;
            end
            if (ram_we)
            begin
                valid_reg[chan_idx] <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                sample_reg[i] <= LEVEL_W'(raw[i][SAMPLE_BITS-1:0]);
            end
            joy_reg <= acq.joystick_levels;
        end
        if (ram_we)
        begin
            level_reg <= new_level;
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign frame.valid      = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_last = out_last_reg;

endmodule

// ----- tb/sv/efsf_frame_checker.sv -----
// Frame checker: follows register writes, predicts the frame of each acquisition, compares bytes.
module efsf_frame_checker
    import efsf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    efsf_acq_if               acq,
    efsf_frame_if             frame,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_beat_t;

    frame_beat_t         expected_bytes[$];
    logic [FACTOR_W-1:0] cur_factor;
    logic [COUNT_W-1:0]  cur_count;
    logic [LEVEL_W-1:0]  level_mem [MAX_CHANNELS];
    int                  err_total;

    // Exact Q0.16 blend of the previous level and the new sample, truncated.
    function automatic logic [LEVEL_W-1:0] ema_next(input logic [LEVEL_W-1:0]  prev,
                                                    input logic [SAMPLE_W-1:0] smp,
                                                    input logic [FACTOR_W-1:0] f);
        logic [47:0] acc;
        acc = 48'(prev) * 48'(f) + ((48'd1 << FACTOR_W) - 48'(f)) * 48'(smp);
        return acc[FACTOR_W +: LEVEL_W];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        logic [SAMPLE_W-1:0] samples [MAX_CHANNELS];
        logic [LEVEL_W-1:0]  v;
        logic [JOY_W-1:0]    joy;
        frame_beat_t         want;
        int                  n;
        if (!rst_n)
        begin
            cur_factor = FACTOR_RESET;
            cur_count  = COUNT_RESET;
            for (int c = 0; c < MAX_CHANNELS; c++)
                level_mem[c] = '0;
            expected_bytes.delete();
            err_total = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_W-1:2] == REG_FACTOR)
                    cur_factor = pwdata[FACTOR_W-1:0];
                else if (paddr[ADDR_W-1:2] == REG_COUNT)
                    cur_count = pwdata[COUNT_W-1:0];
            end

            // Pop before push: a byte on the output always belongs to an older acquisition.
            if (frame.valid && frame.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected frame transaction: frame_byte %0d frame_last %0b",
                           frame.frame_byte, frame.frame_last);
                    err_total++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (frame.frame_byte !== want.data)
                    begin
                        $error("frame_byte: expected %0d, actual %0d",
                               want.data, frame.frame_byte);
                        err_total++;
                    end
                    if (frame.frame_last !== want.last)
                    begin
                        $error("frame_last: expected %0b, actual %0b",
                               want.last, frame.frame_last);
                        err_total++;
                    end
                end
            end

            if (acq.valid && acq.ready)
            begin
                samples[0] = acq.sample_zero;
                samples[1] = acq.sample_one;
                samples[2] = acq.sample_two;
                samples[3] = acq.sample_three;
                joy = acq.joystick_levels;
                // Saturate the channel count at the number of channels present.
                n = (cur_count > MAX_CHANNELS) ? MAX_CHANNELS : int'(cur_count);
                for (int c = 0; c < n; c++)
                begin
                    v = ema_next(level_mem[c], samples[c] & SAMPLE_MASK, cur_factor);
                    level_mem[c] = v;
                    expected_bytes.push_back('{BYTE_W'(v >> DIGIT_SHIFT), 1'b0});
                    expected_bytes.push_back('{BYTE_W'(v[DIGIT_SHIFT-1:0]), 1'b0});
                end
                // Pin 0 lands on bit 3, inverted since the pins are active low.
                expected_bytes.push_back('{BYTE_W'({~joy[0], ~joy[1], ~joy[2], ~joy[3]}), 1'b0});
                expected_bytes.push_back('{TERMINATOR, 1'b1});
            end

            mismatches  <= err_total;
            outstanding <= expected_bytes.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the sensor framer testbench: clock, reset, stimulus, receiver and verdict.
module testbench
    import efsf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ADDR_W-1:0] FACTOR_ADDR = {REG_FACTOR, 2'b00};
    localparam logic [ADDR_W-1:0] COUNT_ADDR  = {REG_COUNT, 2'b00};

    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int LONG_HOLD       = 250;
    localparam int SETTLE_CYCLES   = 30;
    localparam int CYCLE_LIMIT     = 200000;

    logic              clk     = 1'b0;
    logic              rst_n   = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bit          gaps_on       = 1'b1;
    int          hold_req      = 0;
    int          items_sent    = 0;
    int          settings_used = 0;
    int          chk_mismatches;
    int          outstanding;
    int unsigned cycle_count   = 0;

    efsf_acq_if   acq_ch ();
    efsf_frame_if frame_ch ();

    ema_filter_sensor_framer_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .acq     (acq_ch),
        .frame   (frame_ch)
    );

    efsf_frame_checker frame_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .acq         (acq_ch),
        .frame       (frame_ch),
        .mismatches  (chk_mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[ema_filter_sensor_framer_top] ERROR");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_acq(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
                            input logic [SAMPLE_W-1:0] s2, input logic [SAMPLE_W-1:0] s3,
                            input logic [JOY_W-1:0] joy);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            acq_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        acq_ch.valid           <= 1'b1;
        acq_ch.sample_zero     <= s0;
        acq_ch.sample_one      <= s1;
        acq_ch.sample_two      <= s2;
        acq_ch.sample_three    <= s3;
        acq_ch.joystick_levels <= joy;
        do @(posedge clk); while (!(acq_ch.valid && acq_ch.ready));
        items_sent++;
    endtask

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait until every frame byte is back, then let the sequencer settle.
    task automatic drain_frames();
        acq_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [FACTOR_W-1:0] factor,
                                 input logic [COUNT_W-1:0] count);
        drain_frames();
        reg_write(FACTOR_ADDR, DATA_W'(factor));
        reg_write(COUNT_ADDR, DATA_W'(count));
        settings_used++;
    endtask

    initial
    begin : frame_sink
        int gap;
        int hold_done;
        hold_done = 0;
        frame_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            // Hold off for a long stretch so the block backs up into its input.
            if (hold_done != hold_req)
            begin
                frame_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done++;
            end
            gap = gaps_on ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                frame_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            frame_ch.ready <= 1'b1;
            do @(posedge clk); while (!(frame_ch.valid && frame_ch.ready));
        end
    end

    initial
    begin : stimulus
        acq_ch.valid           <= 1'b0;
        acq_ch.sample_zero     <= '0;
        acq_ch.sample_one      <= '0;
        acq_ch.sample_two      <= '0;
        acq_ch.sample_three    <= '0;
        acq_ch.joystick_levels <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Power-on settings: factor one half, two channels.
        send_acq('1, '1, '1, '1, 4'b0000);
        send_acq('0, '0, '0, '0, 4'b1111);
        send_acq(10'h2AA, 10'h155, 10'h2AA, 10'h155, 4'b0101);
        send_acq(10'h155, 10'h2AA, 10'h155, 10'h2AA, 4'b1010);

        // Factor zero: the level follows the sample.
        apply_setting('0, 3'd4);
        send_acq('1, '0, '1, '0, 4'b0000);
        send_acq('0, '1, '0, '1, 4'b1111);
        send_acq('1, '1, '1, '1, 4'b0001);

        // Largest factor: the level barely moves.
        apply_setting('1, 3'd4);
        send_acq('0, '0, '0, '0, 4'b0001);
        send_acq('1, '1, '1, '1, 4'b1000);

        // No active channel: button byte and terminator only.
        apply_setting(FACTOR_RESET, 3'd0);
        send_acq('1, '1, '1, '1, 4'b0110);
        send_acq('0, '0, '0, '0, 4'b1001);

        // Counts above four saturate.
        apply_setting(16'd1, 3'd7);
        send_acq('1, '0, '1, '0, 4'b0010);
        send_acq('0, '1, '0, '1, 4'b0100);
        apply_setting(16'h4000, 3'd5);
        send_acq('1, 10'h155, 10'h2AA, '1, 4'b1110);

        apply_setting(16'hC000, 3'd1);
        send_acq('1, '1, '1, '1, 4'b1101);
        send_acq('0, '1, '1, '1, 4'b1011);
        apply_setting(16'h8001, 3'd3);
        send_acq(10'h3FE, 10'h001, 10'h200, 10'h1FF, 4'b0111);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            logic [FACTOR_W-1:0] f;
            logic [COUNT_W-1:0]  n;
            case ($urandom_range(0, 5))
                0:       f = '0;
                1:       f = '1;
                2:       f = FACTOR_RESET;
                default: f = FACTOR_W'($urandom);
            endcase
            n = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(0, 7))
                                            : COUNT_W'($urandom_range(1, 4));
            apply_setting(f, n);
            gaps_on <= ($urandom_range(0, 3) != 0);
            if (ph == 2 || ph == 7)
                hold_req <= hold_req + 1;
            repeat (ITEMS_PER_PHASE)
                send_acq(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                         JOY_W'($urandom));
        end

        drain_frames();
        $display("Sent %0d acquisitions over %0d register settings (factor 0..65535, count 0..7),",
                 items_sent, settings_used);
        $display("with random gaps on both sides and two long receiver holds.");
        if (chk_mismatches == 0 && outstanding == 0)
            $display("[ema_filter_sensor_framer_top] OK");
        else
            $display("[ema_filter_sensor_framer_top] ERROR");
        $finish;
    end

endmodule
